>>> hdl/pid_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pid_pkg
// Shared types, constants and control store of the PID step controller.
// ----------------------------------------------------------------------------
package pid_pkg;

	localparam int unsigned DATA_W    = 32;
	localparam int unsigned GAIN16_W  = 16;
	localparam int unsigned DRIVE_W   = 17;
	localparam int unsigned STEP_W    = 3;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned DRIVE_SHIFT = 15;

	localparam logic signed [DATA_W-1:0] INC_LIMIT_POS = 32'sd100000;
	localparam logic signed [DATA_W-1:0] INC_LIMIT_NEG = -32'sd100000;
	localparam logic [DATA_W-1:0] ROUND_BIAS = (DATA_W)'((1 << DRIVE_SHIFT) - 1);

	typedef logic [STEP_W-1:0] step_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PROP_GAIN      = 3'd0,
		CFG_INTEG_GAIN     = 3'd1,
		CFG_DERIV_GAIN     = 3'd2,
		CFG_PERIOD_MS      = 3'd3,
		CFG_PERIOD_INVERSE = 3'd4
	} cfg_idx_t;

	typedef enum logic [1:0] {
		MA_ERR  = 2'd0,
		MA_PROD = 2'd1,
		MA_DIFF = 2'd2
	} mul_a_sel_t;

	typedef enum logic [2:0] {
		MB_KI   = 3'd0,
		MB_PMS  = 3'd1,
		MB_KP   = 3'd2,
		MB_KD   = 3'd3,
		MB_PINV = 3'd4
	} mul_b_sel_t;

	typedef enum logic [1:0] {
		TOT_HOLD = 2'd0,
		TOT_LOAD = 2'd1,
		TOT_ADD  = 2'd2
	} tot_op_t;

	typedef enum logic [1:0] {
		JMP_NEXT = 2'd0,
		JMP_IN   = 2'd1,
		JMP_OUT  = 2'd2
	} jump_t;

	typedef struct packed {
		mul_a_sel_t mul_a;
		mul_b_sel_t mul_b;
		logic       mul_en;
		logic       diff_en;
		logic       isum_en;
		logic       prev_en;
		tot_op_t    tot_op;
		logic       out_en;
		jump_t      jump;
	} ctrl_word_t;

	localparam ctrl_word_t CW_NOP = '{
		mul_a: MA_ERR, mul_b: MB_KI, mul_en: 1'b0, diff_en: 1'b0, isum_en: 1'b0,
		prev_en: 1'b0, tot_op: TOT_HOLD, out_en: 1'b0, jump: JMP_NEXT
	};

	// control store
	function automatic ctrl_word_t program_rom(input step_t step);
		ctrl_word_t cw;
		cw = CW_NOP;
		case (step)
			3'd0: begin
				cw.jump = JMP_IN;
			end
			3'd1: begin
				cw.mul_a   = MA_ERR;
				cw.mul_b   = MB_KI;
				cw.mul_en  = 1'b1;
				cw.diff_en = 1'b1;
			end
			3'd2: begin
				cw.mul_a  = MA_PROD;
				cw.mul_b  = MB_PMS;
				cw.mul_en = 1'b1;
			end
			3'd3: begin
				cw.isum_en = 1'b1;
				cw.mul_a   = MA_ERR;
				cw.mul_b   = MB_KP;
				cw.mul_en  = 1'b1;
			end
			3'd4: begin
				cw.tot_op = TOT_LOAD;
				cw.mul_a  = MA_DIFF;
				cw.mul_b  = MB_KD;
				cw.mul_en = 1'b1;
			end
			3'd5: begin
				cw.mul_a   = MA_PROD;
				cw.mul_b   = MB_PINV;
				cw.mul_en  = 1'b1;
				cw.prev_en = 1'b1;
			end
			3'd6: begin
				cw.tot_op = TOT_ADD;
			end
			3'd7: begin
				cw.out_en = 1'b1;
				cw.jump   = JMP_OUT;
			end
			default: begin
				cw = CW_NOP;
			end
		endcase
		return cw;
	endfunction

endpackage
`default_nettype wire

>>> hdl/pid_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pid_if
// Valid/ready channels of the PID step controller: sample in, drive out.
// ----------------------------------------------------------------------------
interface pid_in_if;
	logic                                valid;
	logic                                ready;
	logic signed [pid_pkg::DATA_W-1:0]   measured;
	logic signed [pid_pkg::DATA_W-1:0]   target;

	modport source (output valid, output measured, output target, input ready);
	modport sink   (input valid, input measured, input target, output ready);
endinterface

interface pid_out_if;
	logic                                valid;
	logic                                ready;
	logic signed [pid_pkg::DRIVE_W-1:0]  drive;

	modport source (output valid, output drive, input ready);
	modport sink   (input valid, input drive, output ready);
endinterface
`default_nettype wire

>>> hdl/pid_controller_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pid_controller_step
// Discrete PID step: one drive value per measured/set-point transaction.
// ----------------------------------------------------------------------------
// sample channel: measured value and set point, valid/ready
// result channel: 17-bit signed drive, valid/ready, one per sample
// cfg port: cfg_we, cfg_index, cfg_data; write gains and periods while idle
// a transaction runs from acceptance through the program steps to the drive
// being offered; the next sample is taken once the program returns to its
// wait step, set by an 8-step control program sharing one 32x32 multiplier
// the drive sits in an output register, so a new sample is accepted while
// it waits; if the receiver stalls, the last program step holds until the
// output register is free, and no sample is accepted meanwhile
// reset clears the gains, periods, integral sum and previous error, and
// returns the program to its wait step
// ----------------------------------------------------------------------------
module pid_controller_step (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	pid_in_if.sink                                    sample,
	pid_out_if.source                                 result,
	input  wire logic                                 cfg_we,
	input  wire logic [pid_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire logic [pid_pkg::DATA_W-1:0]           cfg_data
);

	localparam int unsigned W = pid_pkg::DATA_W;

	logic [W-1:0] kp_q, kd_q;
	logic signed [pid_pkg::GAIN16_W-1:0] ki_q;
	logic [pid_pkg::GAIN16_W-1:0] pms_q, pinv_q;

	pid_pkg::step_t     pc_q, pc_next;
	pid_pkg::ctrl_word_t cw;

	logic [W-1:0] err_q, diff_q, prev_q, isum_q, prod_q, tot_q;
	logic [W-1:0] mul_a, mul_b, inc_clamped, tot_biased;
	logic [pid_pkg::DRIVE_W-1:0] drive_q;
	logic out_valid_q;
	logic slot_free, take_in, write_out;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q   <= '0;
			ki_q   <= '0;
			kd_q   <= '0;
			pms_q  <= '0;
			pinv_q <= '0;
		end else if (cfg_we) begin
			case (pid_pkg::cfg_idx_t'(cfg_index))
				pid_pkg::CFG_PROP_GAIN:      kp_q   <= cfg_data;
				pid_pkg::CFG_INTEG_GAIN:     ki_q   <= cfg_data[pid_pkg::GAIN16_W-1:0];
				pid_pkg::CFG_DERIV_GAIN:     kd_q   <= cfg_data;
				pid_pkg::CFG_PERIOD_MS:      pms_q  <= cfg_data[pid_pkg::GAIN16_W-1:0];
				pid_pkg::CFG_PERIOD_INVERSE: pinv_q <= cfg_data[pid_pkg::GAIN16_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer
	assign cw        = pid_pkg::program_rom(pc_q);
	assign slot_free = !out_valid_q || result.ready;
	assign take_in   = (cw.jump == pid_pkg::JMP_IN) && sample.valid;
	assign write_out = cw.out_en && slot_free;

	assign sample.ready = (cw.jump == pid_pkg::JMP_IN);

	always_comb begin
		case (cw.jump)
			pid_pkg::JMP_IN:   pc_next = take_in ? pc_q + 1'b1 : pc_q;
			pid_pkg::JMP_OUT:  pc_next = slot_free ? '0 : pc_q;
			pid_pkg::JMP_NEXT: pc_next = pc_q + 1'b1;
			default:           pc_next = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= '0;
		end else begin
			pc_q <= pc_next;
		end
	end

	// shared multiplier operands
	always_comb begin
		case (cw.mul_a)
			pid_pkg::MA_ERR:  mul_a = err_q;
			pid_pkg::MA_PROD: mul_a = prod_q;
			pid_pkg::MA_DIFF: mul_a = diff_q;
			default:          mul_a = err_q;
		endcase
		case (cw.mul_b)
			pid_pkg::MB_KI:   mul_b = W'(ki_q);
			pid_pkg::MB_PMS:  mul_b = {{(W-pid_pkg::GAIN16_W){1'b0}}, pms_q};
			pid_pkg::MB_KP:   mul_b = kp_q;
			pid_pkg::MB_KD:   mul_b = kd_q;
			pid_pkg::MB_PINV: mul_b = {{(W-pid_pkg::GAIN16_W){1'b0}}, pinv_q};
			default:          mul_b = kp_q;
		endcase
	end

	// increment clamp
	always_comb begin
		if ($signed(prod_q) <= pid_pkg::INC_LIMIT_NEG) begin
			inc_clamped = pid_pkg::INC_LIMIT_NEG;
		end else if ($signed(prod_q) >= pid_pkg::INC_LIMIT_POS) begin
			inc_clamped = pid_pkg::INC_LIMIT_POS;
		end else begin
			inc_clamped = prod_q;
		end
	end

	// truncation toward zero on the divide by 32768
	assign tot_biased = tot_q + (tot_q[W-1] ? pid_pkg::ROUND_BIAS : '0);

	// datapath
	always_ff @(posedge clk) begin
		if (take_in) begin
			err_q <= sample.target - sample.measured;
		end
		if (cw.mul_en) begin
			prod_q <= W'(mul_a * mul_b);
		end
		if (cw.diff_en) begin
			diff_q <= err_q - prev_q;
		end
		case (cw.tot_op)
			pid_pkg::TOT_LOAD: tot_q <= prod_q + isum_q;
			pid_pkg::TOT_ADD:  tot_q <= tot_q + prod_q;
			pid_pkg::TOT_HOLD: tot_q <= tot_q;
			default:           tot_q <= tot_q;
		endcase
		if (write_out) begin
			drive_q <= tot_biased[W-1:pid_pkg::DRIVE_SHIFT];
		end
	end

	// kept state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			isum_q <= '0;
			prev_q <= '0;
		end else begin
			if (cw.isum_en) begin
				isum_q <= isum_q + inc_clamped;
			end
			if (cw.prev_en) begin
				prev_q <= err_q;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (write_out) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign result.valid = out_valid_q;
	assign result.drive = drive_q;

endmodule
`default_nettype wire
